// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared widths, operation codes and status codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned VERTEX_BITS = 10;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DECREASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELMIN   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

// ===== rtl/spq_mem.sv =====
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 42
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Min-priority queue of vertex numbers kept in ascending key order in one
// entry memory; insert, decrease key and delete minimum.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, func_i, vertex_i,    | to block
//          | key_i                                        |
//  out     | out_valid_o, out_ready_i, out_vertex_o,      | from block
//          | out_key_o, now_empty_o, status_o             |
//
//  One word is processed at a time. Entries move through the single read and
//  single write port of the entry memory, one entry per cycle: insert moves
//  each entry with a larger key, delete minimum each entry after the head,
//  decrease key searches, closes the gap and inserts the vertex anew.
//  Reset leaves the queue empty; the memory itself needs no clearing.
//  A finished result waits in the output register while the next word is
//  taken; work stalls at its end only when that register is still full.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned CAPACITY    = spq_pkg::CAPACITY,
  parameter int unsigned VERTEX_BITS = spq_pkg::VERTEX_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [spq_pkg::FUNC_W-1:0]    func_i,
  input  logic [VERTEX_BITS-1:0]        vertex_i,
  input  logic [spq_pkg::KEY_W-1:0]     key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [VERTEX_BITS-1:0]        out_vertex_o,
  output logic [spq_pkg::KEY_W-1:0]     out_key_o,
  output logic                          now_empty_o,
  output logic [spq_pkg::STATUS_W-1:0]  status_o
);

  import spq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = VERTEX_BITS + KEY_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS_GO = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_HEAD   = 3'd4;
  localparam logic [2:0] S_SRCH   = 3'd5;
  localparam logic [2:0] S_SHDN   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [FUNC_W-1:0]      func_q, func_d;
  logic [VERTEX_BITS-1:0] vtx_q, vtx_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [VERTEX_BITS-1:0] res_vtx_q, res_vtx_d;
  logic [KEY_W-1:0]       res_key_q, res_key_d;
  logic [STATUS_W-1:0]    res_st_q, res_st_d;
  logic                   out_valid_q, out_valid_d;
  logic [VERTEX_BITS-1:0] out_vtx_q;
  logic [KEY_W-1:0]       out_key_q;
  logic                   out_empty_q;
  logic [STATUS_W-1:0]    out_st_q;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [DW-1:0]          mem_wdata, mem_rdata;

  logic [KEY_W-1:0]       rd_key;
  logic [VERTEX_BITS-1:0] rd_vtx;
  logic [DW-1:0]          new_entry;
  logic                   last_w;
  logic [AW-1:0]          ptr_inc, ptr_dec;
  logic [CW-1:0]          cnt_m1;
  logic                   out_load;

  spq_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (AW),
    .DATA_W (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_key    = mem_rdata[KEY_W-1:0];
  assign rd_vtx    = mem_rdata[DW-1:KEY_W];
  assign new_entry = {vtx_q, key_q};
  assign last_w    = ((CW'(ptr_q) + CW'(1)) == count_q);
  assign ptr_inc   = ptr_q + AW'(1);
  assign ptr_dec   = ptr_q - AW'(1);
  assign cnt_m1    = count_q - CW'(1);
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    func_d    = func_q;
    vtx_d     = vtx_q;
    key_d     = key_q;
    res_vtx_d = res_vtx_q;
    res_key_d = res_key_q;
    res_st_d  = res_st_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_i;
          vtx_d     = vertex_i;
          key_d     = key_i;
          res_vtx_d = '0;
          res_key_d = '0;
          res_st_d  = ST_OK;
          unique case (func_i)
            FUNC_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                res_st_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_INS_GO;
              end
            end
            FUNC_DECREASE: begin
              if (count_q == '0) begin
                res_st_d = ST_NOTFOUND;
                state_d  = S_DONE;
              end else begin
                mem_re  = 1'b1;
                ptr_d   = '0;
                state_d = S_SRCH;
              end
            end
            FUNC_DELMIN: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                mem_re  = 1'b1;
                state_d = S_HEAD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INS_GO: begin
        // walk from the tail toward the head, moving larger keys up one place
        if (count_q == '0) begin
          mem_we    = 1'b1;
          mem_wdata = new_entry;
          count_d   = count_q + CW'(1);
          state_d   = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_m1[AW-1:0];
          ptr_d     = cnt_m1[AW-1:0];
          state_d   = S_INS;
        end
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_inc;
        if (rd_key > key_q) begin
          mem_wdata = mem_rdata;
          if (ptr_q == '0) begin
            state_d = S_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr_dec;
            ptr_d     = ptr_dec;
          end
        end else begin
          mem_wdata = new_entry;
          count_d   = count_q + CW'(1);
          state_d   = S_DONE;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = new_entry;
        count_d   = count_q + CW'(1);
        state_d   = S_DONE;
      end
      S_HEAD: begin
        res_vtx_d = rd_vtx;
        res_key_d = rd_key;
        if (count_q == CW'(1)) begin
          count_d = '0;
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(1);
          ptr_d     = AW'(1);
          state_d   = S_SHDN;
        end
      end
      S_SRCH: begin
        if (rd_vtx == vtx_q) begin
          if (last_w) begin
            count_d = cnt_m1;
            state_d = S_INS_GO;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr_inc;
            ptr_d     = ptr_inc;
            state_d   = S_SHDN;
          end
        end else if (last_w) begin
          res_st_d = ST_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc;
          ptr_d     = ptr_inc;
        end
      end
      S_SHDN: begin
        // close the gap: move each later entry down one place
        mem_we    = 1'b1;
        mem_waddr = ptr_dec;
        mem_wdata = mem_rdata;
        if (last_w) begin
          count_d = cnt_m1;
          state_d = (func_q == FUNC_DELMIN) ? S_DONE : S_INS_GO;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc;
          ptr_d     = ptr_inc;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    func_q    <= func_d;
    vtx_q     <= vtx_d;
    key_q     <= key_d;
    res_vtx_q <= res_vtx_d;
    res_key_q <= res_key_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_vtx_q   <= res_vtx_q;
      out_key_q   <= res_key_q;
      out_empty_q <= (count_q == '0);
      out_st_q    <= res_st_q;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vtx_q;
  assign out_key_o    = out_key_q;
  assign now_empty_o  = out_empty_q;
  assign status_o     = out_st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
    else $error("memory write outside an operation");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_st_q == ST_FULL) |-> (count_q == CW'(CAPACITY)))
    else $error("full status with room left");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && $past(state_q) != S_IDLE && count_q > $past(count_q))
      |-> (count_q == $past(count_q) + CW'(1)))
    else $error("entry count grew by more than one");

endmodule
